[hdl/ddz_pkg.sv]
// ----------------------------------------------------------------------------
// ddz_pkg
// shared types and codes for the delta-of-delta zigzag codec
// ----------------------------------------------------------------------------
package ddz_pkg;

  localparam int unsigned WORD_BITS          = 64;
  localparam int unsigned VALUE_BITS_DEFAULT = 64;
  localparam int unsigned CFG_DATA_BITS      = 2;
  localparam int unsigned CFG_INDEX_BITS     = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ELEM_SIZE = 1'd1;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // block phase codes
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_DELTA = 2'd1;
  localparam logic [1:0] PHASE_DOD   = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_DELTA = 2'd1;
  localparam logic [1:0] KIND_DOD   = 2'd2;

  localparam logic [1:0] ELEM_SIZE_RESET = 2'd3;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 start;
  } ddz_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [1:0]           kind;
  } ddz_result_t;

  // element width in bits: 8, 16, 32 or 64
  function automatic logic [6:0] elem_bits_of(input logic [1:0] code);
    logic [6:0] bits;
    unique case (code)
      2'd0: bits = 7'd8;
      2'd1: bits = 7'd16;
      2'd2: bits = 7'd32;
      2'd3: bits = 7'd64;
      default: bits = 7'd64;
    endcase
    return bits;
  endfunction

endpackage

[hdl/ddz_in_if.sv]
// ----------------------------------------------------------------------------
// ddz_in_if
// input channel: valid/ready with one word and the block start mark
// ----------------------------------------------------------------------------
interface ddz_in_if import ddz_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] in_word;
  logic                 block_start;

  modport source (output valid, output in_word, output block_start, input ready);
  modport sink (input valid, input in_word, input block_start, output ready);
endinterface

[hdl/ddz_out_if.sv]
// ----------------------------------------------------------------------------
// ddz_out_if
// result channel: valid/ready with one word and its kind
// ----------------------------------------------------------------------------
interface ddz_out_if import ddz_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] out_word;
  logic [1:0]           out_kind;

  modport source (output valid, output out_word, output out_kind, input ready);
  modport sink (input valid, input out_word, input out_kind, output ready);
endinterface

[hdl/ddz_datapath.sv]
// ----------------------------------------------------------------------------
// ddz_datapath
// one encode or decode step: delta, delta-of-delta, zigzag, sign extension
// ----------------------------------------------------------------------------
module ddz_datapath import ddz_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  direction,
  input  logic [1:0]            element_size_code,
  input  ddz_item_t             item,
  input  logic [VALUE_BITS-1:0] held_value,
  input  logic [VALUE_BITS-1:0] held_delta,
  input  logic [1:0]            phase,
  output logic [VALUE_BITS-1:0] held_value_next,
  output logic [VALUE_BITS-1:0] held_delta_next,
  output logic [1:0]            phase_next,
  output ddz_result_t           result
);

  localparam int unsigned W = VALUE_BITS;

  logic [6:0]           elem_raw;
  logic [6:0]           elem_bits;
  logic [5:0]           elem_top;
  logic [1:0]           cur_phase;
  logic [WORD_BITS-1:0] word_sx;
  logic [W-1:0]         x;
  logic [W-1:0]         delta_enc;
  logic [W-1:0]         dod;
  logic [W-1:0]         zz_in;
  logic [W-1:0]         zz_code;
  logic [W-1:0]         code_in;
  logic [W-1:0]         zz_dec;
  logic [W-1:0]         delta_dec;
  logic [W-1:0]         value_dec;
  logic [WORD_BITS-1:0] value_full;
  logic [WORD_BITS-1:0] value_sx;

  // element width, capped at the arithmetic width
  assign elem_raw  = elem_bits_of(element_size_code);
  assign elem_bits = (elem_raw > 7'(W)) ? 7'(W) : elem_raw;
  assign elem_top  = 6'(elem_bits - 7'd1);

  // a start mark always restarts the block
  assign cur_phase = item.start ? PHASE_FIRST : phase;

  // encode side
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      word_sx[i] = (7'(i) < elem_bits) ? item.word[i] : item.word[elem_top];
    end
  end

  assign x         = word_sx[W-1:0];
  assign delta_enc = x - held_value;
  assign dod       = delta_enc - held_delta;
  assign zz_in     = (cur_phase == PHASE_DELTA) ? delta_enc : dod;
  assign zz_code   = {zz_in[W-2:0], 1'b0} ^ {W{zz_in[W-1]}};

  // decode side
  assign code_in   = item.word[W-1:0];
  assign zz_dec    = (code_in >> 1) ^ {W{code_in[0]}};
  assign delta_dec = (cur_phase == PHASE_DELTA) ? zz_dec : held_delta + zz_dec;
  assign value_dec = (cur_phase == PHASE_FIRST) ? code_in : held_value + delta_dec;

  // narrow the rebuilt value to the element and sign-extend to the word
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      value_full[i] = value_dec[(i < W) ? i : W - 1];
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      value_sx[i] = (7'(i) < elem_bits) ? value_full[i] : value_full[elem_top];
    end
  end

  always_comb begin
    unique case (cur_phase)
      PHASE_FIRST: begin
        phase_next  = PHASE_DELTA;
        result.kind = KIND_FIRST;
      end
      PHASE_DELTA: begin
        phase_next  = PHASE_DOD;
        result.kind = KIND_DELTA;
      end
      default: begin
        phase_next  = PHASE_DOD;
        result.kind = KIND_DOD;
      end
    endcase

    if (direction == DIR_ENCODE) begin
      held_value_next = x;
      held_delta_next = (cur_phase == PHASE_FIRST) ? held_delta : delta_enc;
      result.word     = (cur_phase == PHASE_FIRST) ? word_sx : WORD_BITS'(zz_code);
    end else begin
      held_value_next = value_dec;
      held_delta_next = (cur_phase == PHASE_FIRST) ? held_delta : delta_dec;
      result.word     = value_sx;
    end
  end

endmodule

[hdl/delta_of_delta_zigzag_codec.sv]
// ----------------------------------------------------------------------------
// delta_of_delta_zigzag_codec
// streaming delta-of-delta zigzag encoder / decoder for integer columns
// ----------------------------------------------------------------------------
// path: an input transfer is captured in the input register, then its result
//   in the result register; a step is taken only while the result register is free
// throughput: one item per cycle while the result register can advance, set by the
//   state update loop (previous value, previous delta, phase) in the step datapath
// reset: synchronous, clears both stages, the block state and the registers
//   (direction encode, element size 8 bytes)
module delta_of_delta_zigzag_codec import ddz_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  ddz_in_if.sink                    in_ch,
  ddz_out_if.source                 out_ch
);

  // configuration registers
  logic       direction;
  logic [1:0] element_size_code;

  // input stage
  logic      s1_valid;
  ddz_item_t s1_item;

  // block state
  logic [VALUE_BITS-1:0] held_value;
  logic [VALUE_BITS-1:0] held_delta;
  logic [1:0]            phase;

  // datapath outputs
  logic [VALUE_BITS-1:0] held_value_next;
  logic [VALUE_BITS-1:0] held_delta_next;
  logic [1:0]            phase_next;
  ddz_result_t           result_next;

  // result register
  logic        out_valid;
  ddz_result_t out_result;

  logic advance;
  logic step;

  // the result register frees up when empty or when its transfer completes
  assign advance = !out_valid || out_ch.ready;
  // an item is processed whenever the input stage holds one and can move on
  assign step    = s1_valid && advance;

  assign in_ch.ready     = !s1_valid || advance;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_word = out_result.word;
  assign out_ch.out_kind = out_result.kind;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction         <= DIR_ENCODE;
      element_size_code <= ELEM_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_ELEM_SIZE: element_size_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.word  <= in_ch.in_word;
      s1_item.start <= in_ch.block_start;
    end
  end

  // single step of the codec between the two registers
  ddz_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .direction         (direction),
    .element_size_code (element_size_code),
    .item              (s1_item),
    .held_value        (held_value),
    .held_delta        (held_delta),
    .phase             (phase),
    .held_value_next   (held_value_next),
    .held_delta_next   (held_delta_next),
    .phase_next        (phase_next),
    .result            (result_next)
  );

  // block state, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= '0;
      held_delta <= '0;
      phase      <= PHASE_FIRST;
    end else if (step) begin
      held_value <= held_value_next;
      held_delta <= held_delta_next;
      phase      <= phase_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result_next;
    end
  end

  // a marked item always comes out as a first value
  assert property (@(posedge clk) disable iff (rst)
    (step && s1_item.start) |=> (out_ch.valid && out_ch.out_kind == KIND_FIRST))
    else $error("block start did not produce a first value");

  // the item after a first value is a first delta unless it restarts the block
  assert property (@(posedge clk) disable iff (rst)
    (step && !s1_item.start && phase == PHASE_DELTA) |=>
      (out_ch.valid && out_ch.out_kind == KIND_DELTA))
    else $error("second item of a block is not a first delta");

  // once in delta-of-delta items, only a start mark leaves that phase
  assert property (@(posedge clk) disable iff (rst)
    (step && !s1_item.start && phase == PHASE_DOD) |=> (phase == PHASE_DOD))
    else $error("block left delta-of-delta phase without a start mark");

  // a waiting result is never overwritten by a new step
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !step)
    else $error("step taken while a result is stalled");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the delta-of-delta zigzag codec: a scoreboard
// class tracks block state and mode to predict every output, tasks drive
// directed corner items and then random column-like blocks in all modes
// ----------------------------------------------------------------------------
module tb_top;
  import ddz_pkg::*;

  localparam int unsigned VB = VALUE_BITS_DEFAULT;

  // mask of the low bits, all ones at 64 and above
  function automatic logic [63:0] lmask(input int unsigned bits);
    if (bits >= 64) begin
      return '1;
    end
    return (64'd1 << bits) - 64'd1;
  endfunction

  // sign extension from the low bits to the full word
  function automatic logic [63:0] sext(input logic [63:0] v, input int unsigned bits);
    logic signed [63:0] t;
    if (bits >= 64) begin
      return v;
    end
    t = v << (64 - bits);
    return t >>> (64 - bits);
  endfunction

  // element width in bits for a size code, capped at the arithmetic width
  function automatic int unsigned width_of(input logic [1:0] code);
    int unsigned w;
    w = 8 << code;
    if (w > VB) begin
      w = VB;
    end
    return w;
  endfunction

  // tracks codec state, predicts one output per input transfer
  class codec_scoreboard;
    logic        dir;
    logic [1:0]  esize;
    logic [63:0] last_value;
    logic [63:0] last_delta;
    logic [1:0]  phase;
    ddz_result_t awaited[$];
    int          errors;
    int          checked;

    function new();
      dir        = DIR_ENCODE;
      esize      = ELEM_SIZE_RESET;
      last_value = '0;
      last_delta = '0;
      phase      = PHASE_FIRST;
      errors     = 0;
      checked    = 0;
    endfunction

    function logic [63:0] zigzag(input logic [63:0] v);
      return ((v << 1) ^ {64{v[63]}}) & lmask(VB);
    endfunction

    function logic [63:0] unzigzag(input logic [63:0] c);
      logic [63:0] m;
      m = c & lmask(VB);
      return sext((m >> 1) ^ (64'd0 - (m & 64'd1)), VB);
    endfunction

    function void absorb_item(input logic [63:0] word, input logic start);
      int unsigned ew;
      logic [63:0] x;
      logic [63:0] delta;
      ddz_result_t r;
      ew = width_of(esize);
      if (start) begin
        phase = PHASE_FIRST;
      end
      if (dir == DIR_ENCODE) begin
        x = sext(word, ew);
        if (phase == PHASE_FIRST) begin
          r.word = x;
          r.kind = KIND_FIRST;
          phase  = PHASE_DELTA;
        end else if (phase == PHASE_DELTA) begin
          delta      = sext(x - last_value, VB);
          r.word     = zigzag(delta);
          r.kind     = KIND_DELTA;
          last_delta = delta;
          phase      = PHASE_DOD;
        end else begin
          delta      = sext(x - last_value, VB);
          r.word     = zigzag(sext(delta - last_delta, VB));
          r.kind     = KIND_DOD;
          last_delta = delta;
        end
        last_value = x;
      end else begin
        if (phase == PHASE_FIRST) begin
          last_value = sext(word, VB);
          r.kind     = KIND_FIRST;
          phase      = PHASE_DELTA;
        end else if (phase == PHASE_DELTA) begin
          delta      = unzigzag(word);
          last_delta = delta;
          last_value = sext(last_value + delta, VB);
          r.kind     = KIND_DELTA;
          phase      = PHASE_DOD;
        end else begin
          delta      = sext(last_delta + unzigzag(word), VB);
          last_delta = delta;
          last_value = sext(last_value + delta, VB);
          r.kind     = KIND_DOD;
        end
        r.word = sext(last_value, ew);
      end
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_output(input logic [63:0] word, input logic [1:0] kind);
      ddz_result_t e;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb_top: unexpected output word=%h kind=%0d", word, kind);
        end
        return;
      end
      e = awaited.pop_front();
      if (word !== e.word || kind !== e.kind) begin
        errors++;
        if (errors <= 10) begin
          $display("tb_top: mismatch word exp=%h act=%h kind exp=%0d act=%0d",
                   e.word, word, e.kind, kind);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  ddz_in_if  in_ch ();
  ddz_out_if out_ch ();

  delta_of_delta_zigzag_codec #(.VALUE_BITS(VB)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  codec_scoreboard board = new();

  // idling switches and counters shared between the driver and the receiver
  bit tx_gaps;
  bit rx_gaps;
  int rx_wait;
  int rx_hold;
  int items_sent;
  int settings_used;

  // mode the stimulus is currently built for
  logic       cur_dir;
  logic [1:0] cur_esize;

  always #10 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // output side: checks every transfer, then draws its own stall for the next one;
  // a long hold request from the stimulus overrides the per-item stall
  initial begin
    out_ch.ready <= 1'b0;
    rx_wait = 0;
    rx_hold = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          board.check_output(out_ch.out_word, out_ch.out_kind);
          rx_wait = rx_gaps ? $urandom_range(0, 9) : 0;
        end
        if (rx_hold > 0) begin
          out_ch.ready <= 1'b0;
          rx_hold--;
        end else if (rx_wait > 0) begin
          out_ch.ready <= 1'b0;
          rx_wait--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // offers one item after an optional gap and returns at the edge it transfers;
  // valid is only lowered when a gap follows, so back-to-back items keep it high
  task automatic send_item(input logic [63:0] word, input logic start);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_word     <= word;
    in_ch.block_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    board.absorb_item(word, start);
    items_sent++;
  endtask

  // stop offering and wait until every predicted output has come back,
  // then wait on so the two-stage pipeline settles
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // new mode, written only with the codec idle; block state carries over
  task automatic set_mode(input logic dir, input logic [1:0] esize);
    drain();
    write_reg(CFG_DIRECTION, CFG_DATA_BITS'(dir));
    write_reg(CFG_ELEM_SIZE, esize);
    cfg_we      <= 1'b0;
    board.dir   = dir;
    board.esize = esize;
    cur_dir     = dir;
    cur_esize   = esize;
    settings_used++;
  endtask

  function automatic logic [63:0] small_signed(input int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return 64'(v);
  endfunction

  // word biased toward the interesting corners
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return small_signed(1000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // column-like blocks: a base plus a steady step and a little jitter when
  // encoding, a first value and mostly small codes when decoding; a sprinkle
  // of raw noise words and stray block marks on top
  task automatic run_blocks(input int count);
    int          sent;
    int          len;
    int          i;
    int unsigned ew;
    logic [63:0] base;
    logic [63:0] step;
    logic [63:0] value;
    logic [63:0] word;
    logic        start;
    logic        carry;
    sent  = 0;
    ew    = width_of(cur_esize);
    // sometimes keep the block that was open before the mode change
    carry = ($urandom_range(0, 3) == 0);
    while (sent < count) begin
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      base  = rand_word();
      step  = ($urandom_range(0, 5) == 0) ? rand_word() : small_signed(100);
      value = base;
      for (i = 0; i < len && sent < count; i++) begin
        if (cur_dir == DIR_ENCODE) begin
          if (i > 0) begin
            value = value + step + small_signed(3);
          end
          word = value;
          // junk above the element must be ignored
          if ($urandom_range(0, 1) == 1) begin
            word = (value & lmask(ew)) | ({$urandom, $urandom} & ~lmask(ew));
          end
        end else if (i == 0) begin
          word = base;
        end else if ($urandom_range(0, 7) == 0) begin
          word = rand_word();
        end else begin
          word = 64'($urandom_range(0, 31));
        end
        if ($urandom_range(0, 19) == 0) begin
          word = {$urandom, $urandom};
        end
        start = (i == 0) ? !carry : ($urandom_range(0, 49) == 0);
        carry = 1'b0;
        send_item(word, start);
        sent++;
      end
    end
  endtask

  initial begin
    int         p;
    logic       dir;
    logic [1:0] esize;
    logic [1:0] idle;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_DIRECTION;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.in_word     <= '0;
    in_ch.block_start <= 1'b0;
    items_sent    = 0;
    settings_used = 0;
    cur_dir       = DIR_ENCODE;
    cur_esize     = ELEM_SIZE_RESET;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset mode: encode, 8-byte elements; first item carries no block mark
    send_item(64'h8000_0000_0000_0000, 1'b0);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);   // delta wraps around
    send_item(64'h0, 1'b0);
    send_item('1, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b0);
    // block mark in the middle of a block restarts it
    send_item(64'd42, 1'b1);
    send_item(64'd40, 1'b0);

    // narrow elements without a new mark: state carries across the change
    set_mode(DIR_ENCODE, 2'd0);
    send_item(64'hFFFF_FFFF_FFFF_FF80, 1'b0);
    send_item(64'h1234_5678_9ABC_DE7F, 1'b0);
    send_item(64'h0000_0000_0000_0180, 1'b0);

    // decode: full-width first value, extreme codes
    set_mode(DIR_DECODE, 2'd3);
    send_item(64'h8000_0000_0000_0000, 1'b1);
    send_item('1, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_item(64'd1, 1'b0);
    send_item(64'd0, 1'b0);

    // decode with byte elements: only the output is narrowed
    set_mode(DIR_DECODE, 2'd0);
    send_item(64'h0000_0000_0000_0100, 1'b0);
    send_item(64'h0123_4567_89AB_CDEF, 1'b1);
    send_item(64'd255, 1'b0);
    send_item(64'd2, 1'b0);

    set_mode(DIR_DECODE, 2'd2);
    send_item(64'hFFFF_FFFF_0000_0001, 1'b0);

    set_mode(DIR_ENCODE, 2'd1);
    send_item(64'h0000_0000_ABCD_8000, 1'b1);
    send_item(64'h0000_0000_0000_7FFF, 1'b0);
    send_item(64'h0, 1'b0);

    // random phases: every direction and size first, then random ones;
    // idling varies per phase, including phases with none at all
    for (p = 0; p < 12; p++) begin
      if (p < 8) begin
        dir   = p[0];
        esize = p[2:1];
        idle  = p[1:0];
      end else begin
        dir   = 1'($urandom_range(0, 1));
        esize = 2'($urandom_range(0, 3));
        idle  = 2'($urandom_range(0, 3));
      end
      set_mode(dir, esize);
      tx_gaps = idle[0];
      rx_gaps = idle[1];
      run_blocks(135);
    end

    // back-pressure: output held off while items keep coming at full rate,
    // so the pipeline fills and the input stalls
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold = 80;
    run_blocks(40);

    drain();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d items over %0d register settings, %0d outputs checked",
             items_sent, settings_used, board.checked);
    $display("tb_top: both directions, all element sizes, mid-block marks and mode changes");
    if (board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
